FILE: design/upd_pkg.sv
package upd_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2b;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam int unsigned MAX_OUT   = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// decoded bytes caused by one input item
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [1:0]              cnt;
		logic                    last;
	} group_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

FILE: design/url_percent_decoder.sv
// a decoded byte goes from the front through the group queue into the output register
// throughput: one input item per cycle while the queue has room; the k bytes of one item
//   go out in turn (k up to three, on a malformed escape or end-of-string flush)
// the group queue between front and back absorbs those bursts, QUEUE_DEPTH groups deep
// reset: arst_n clears phase, held character, queue pointers and output valid at once
module url_percent_decoder import upd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_data,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data
);

	// front to queue
	logic   take;
	logic   push;
	group_t push_grp;

	// queue to back
	logic   full;
	logic   gvalid;
	group_t head_grp;
	logic   pop;

	// the front may take an item whenever the queue has room for its group
	assign src_stall = full;
	assign take      = src_valid && !full;

	// escape tracking: phase and held digit, builds the group of decoded bytes
	upd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (src_data),
		.push   (push),
		.grp    (push_grp)
	);

	// groups with no bytes (escape still pending) are never queued
	upd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_grp),
		.full   (full),
		.pop    (pop),
		.rvalid (gvalid),
		.rdata  (head_grp)
	);

	// serializes a group one byte per cycle into the output register unless the output is stalled
	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gvalid    (gvalid),
		.grp       (head_grp),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

FILE: design/upd_front.sv
module upd_front import upd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_item_t item,
	output logic     push,
	output group_t   grp
);

	phase_t     phase_q;
	logic [7:0] held_q;
	phase_t     np;
	logic [7:0] nh;
	logic [7:0] e [MAX_OUT];
	logic [1:0] n;
	logic [7:0] b;

	always_comb begin
		b = item.in_byte;
		np = PH_IDLE;
		nh = 8'h00;
		n = 2'd0;
		for (int i = 0; i < MAX_OUT; i++) begin
			e[i] = 8'h00;
		end
		unique case (phase_q)
			PH_PCT: begin
				if (is_hex(b)) begin
					np = PH_DIGIT;
					nh = b;
				end else begin
					e[n] = PCT_CHAR;
					n = n + 2'd1;
				end
			end
			PH_DIGIT: begin
				if (is_hex(held_q) && is_hex(b)) begin
					e[n] = {hex_val(held_q), hex_val(b)};
					n = n + 2'd1;
				end else begin
					e[n] = PCT_CHAR;
					n = n + 2'd1;
					e[n] = held_q;
					n = n + 2'd1;
				end
			end
			default: ;
		endcase
		// byte handled as plain input unless it was consumed by the escape
		if (!((phase_q == PH_PCT && is_hex(b)) ||
				(phase_q == PH_DIGIT && is_hex(held_q) && is_hex(b)))) begin
			if (b == PCT_CHAR) begin
				np = PH_PCT;
			end else if (b == PLUS_CHAR) begin
				e[n] = SPACE_CHAR;
				n = n + 2'd1;
			end else begin
				e[n] = b;
				n = n + 2'd1;
			end
		end
		// end of string flushes whatever is held
		if (item.in_last) begin
			if (np == PH_PCT || np == PH_DIGIT) begin
				e[n] = PCT_CHAR;
				n = n + 2'd1;
			end
			if (np == PH_DIGIT) begin
				e[n] = nh;
				n = n + 2'd1;
			end
			np = PH_IDLE;
			nh = 8'h00;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_OUT; i++) begin
			grp.bytes[i] = e[i];
		end
		grp.cnt  = n;
		grp.last = item.in_last;
		push     = take && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (take) begin
			phase_q <= np;
			held_q  <= nh;
		end
	end

endmodule

FILE: design/upd_fifo.sv
module upd_fifo import upd_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t wdata,
	output logic   full,
	input  logic   pop,
	output logic   rvalid,
	output group_t rdata
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	group_t          mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/upd_back.sv
module upd_back import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      gvalid,
	input  group_t    grp,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	out_item_t  data_q;
	logic       valid_q;

	assign load      = gvalid && (!valid_q || !dst_stall);
	assign at_end    = (idx_q == grp.cnt - 2'd1);
	assign pop       = load && at_end;
	assign dst_valid = valid_q;
	assign dst_data  = data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.out_byte <= grp.bytes[idx_q];
			data_q.out_last <= grp.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!dst_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import upd_pkg::*;

	localparam int unsigned RAND_ITEMS   = 350;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 10;
	// items sent in this window go through with no idling on either side
	localparam int unsigned CALM_FROM    = 120;
	localparam int unsigned CALM_TO      = 200;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_item_t  src_data = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_item_t dst_data;

	// encoded bytes waiting to go out, decoded bytes waiting to come back
	in_item_t  encoded_q[$];
	out_item_t decoded_q[$];

	// decoder state as the testbench sees it
	phase_t     dec_phase = PH_IDLE;
	logic [7:0] dec_held = '0;

	logic src_took = 1'b0;
	int unsigned sent_cnt = 0;
	int unsigned item_cnt = 0;
	int unsigned byte_cnt = 0;
	int unsigned string_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned quiet_cycles = 0;
	logic calm;

	url_percent_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	always #1 clk = ~clk;

	assign calm = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);

	// bit 4 flags a hex digit, bits 3:0 carry its value
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, c[3:0]};
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return {1'b1, 4'(c[3:0] + 4'd9)};
		return 5'd0;
	endfunction

	// hex digit character for a value, letters in random case
	function automatic logic [7:0] hex_char(input int unsigned v);
		if (v < 10)
			return 8'(8'h30 + v);
		return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
	endfunction

	// work out the decoded bytes one encoded item yields and queue them
	task automatic decode_item(input in_item_t it);
		logic [7:0] outs[$];
		logic [7:0] b;
		logic [4:0] hi;
		logic [4:0] lo;
		logic       redo;
		out_item_t  res;
		b = it.in_byte;
		redo = 1'b0;
		case (dec_phase)
			PH_PCT: begin
				lo = hex_nibble(b);
				if (lo[4]) begin
					dec_held = b;
					dec_phase = PH_DIGIT;
				end else begin
					// malformed: literal percent, then the byte as plain input
					outs.push_back(PCT_CHAR);
					dec_phase = PH_IDLE;
					redo = 1'b1;
				end
			end
			PH_DIGIT: begin
				hi = hex_nibble(dec_held);
				lo = hex_nibble(b);
				if (hi[4] && lo[4]) begin
					outs.push_back({hi[3:0], lo[3:0]});
				end else begin
					// malformed after one digit: percent and digit go out literally
					outs.push_back(PCT_CHAR);
					outs.push_back(dec_held);
					redo = 1'b1;
				end
				dec_phase = PH_IDLE;
				dec_held = '0;
			end
			default: begin
				dec_phase = PH_IDLE;
				redo = 1'b1;
			end
		endcase
		if (redo) begin
			if (b == PCT_CHAR)
				dec_phase = PH_PCT;
			else if (b == PLUS_CHAR)
				outs.push_back(SPACE_CHAR);
			else
				outs.push_back(b);
		end
		// end of string flushes whatever escape is still open
		if (it.in_last) begin
			if (dec_phase != PH_IDLE)
				outs.push_back(PCT_CHAR);
			if (dec_phase == PH_DIGIT)
				outs.push_back(dec_held);
			dec_phase = PH_IDLE;
			dec_held = '0;
		end
		foreach (outs[i]) begin
			res.out_byte = outs[i];
			res.out_last = it.in_last && (i == outs.size() - 1);
			decoded_q.push_back(res);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.in_byte = b;
		it.in_last = last;
		encoded_q.push_back(it);
	endtask

	task automatic add_string(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], i == s.len() - 1);
		string_cnt++;
	endtask

	// source side: a new item goes out once the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || src_took) begin
			if (encoded_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
				src_valid <= 1'b1;
				src_data <= encoded_q.pop_front();
				sent_cnt++;
			end else begin
				src_valid <= 1'b0;
			end
		end
		// sink side: random backpressure outside the calm window
		dst_stall <= arst_n && !calm && ($urandom_range(99) < 20);
	end

	// accepted input items feed the predictor
	always @(posedge clk) begin
		src_took <= src_valid && !src_stall;
		if (arst_n && src_valid && !src_stall) begin
			decode_item(src_data);
			item_cnt++;
		end
	end

	// accepted output items are checked against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			byte_cnt++;
			if (decoded_q.size() == 0) begin
				$error("unexpected item: out_byte %h out_last %b",
					dst_data.out_byte, dst_data.out_last);
				err_cnt++;
			end else begin
				want = decoded_q.pop_front();
				if (dst_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, dst_data.out_byte);
					err_cnt++;
				end
				if (dst_data.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, dst_data.out_last);
					err_cnt++;
				end
			end
		end
	end

	// watchdog: too long with nothing moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles with no progress", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] str_q[$];
		int unsigned n;
		int unsigned pick;

		// directed strings
		add_string("+%41");       // plus to space, escape ending on the final byte
		add_string("%4%");        // broken after one digit, new escape flushed at end
		add_string("%+%fF");      // broken by a plus, then lower and upper case digits
		add_string("%");          // lone percent as the whole string
		add_string("%a");         // percent and one digit flushed at end
		add_byte(8'h00, 1'b0);    // byte extremes passed through
		add_byte(8'hff, 1'b1);
		string_cnt++;
		add_string("%00%9Z");     // zero byte, then broken escape ending the string

		// random strings: mostly well-formed escapes and text, some broken escapes
		while (encoded_q.size() < RAND_ITEMS) begin
			str_q.delete();
			n = $urandom_range(1, 8);
			repeat (n) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					str_q.push_back(8'($urandom_range(255)));
				end else if (pick < 50) begin
					str_q.push_back(PLUS_CHAR);
				end else if (pick < 80) begin
					str_q.push_back(PCT_CHAR);
					str_q.push_back(hex_char($urandom_range(15)));
					str_q.push_back(hex_char($urandom_range(15)));
				end else begin
					// broken: percent, maybe a digit, maybe any byte after
					str_q.push_back(PCT_CHAR);
					if (pick >= 87)
						str_q.push_back(hex_char($urandom_range(15)));
					if (pick < 95)
						str_q.push_back(8'($urandom_range(255)));
				end
			end
			foreach (str_q[i])
				add_byte(str_q[i], i == str_q.size() - 1);
			string_cnt++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all input, then all expected output, then a short drain
		while (encoded_q.size() != 0 || src_valid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d strings, %0d encoded items in, %0d decoded items checked",
			string_cnt, item_cnt, byte_cnt);
		$display("plus signs, good and broken escapes, and end-of-string flushes exercised");
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
